@@ src/sjpq_pkg.sv @@
// ----------------------------------------------------------------------------
// sjpq_pkg
// Shared types, codes and helpers for the sorted job priority queue.
// ----------------------------------------------------------------------------
package sjpq_pkg;

  // default queue depth and field widths
  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned TAG_W         = 16;
  localparam int unsigned TIME_W        = 16;
  localparam int unsigned KEY_W         = TIME_W + 1;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned OCC_W         = 5;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // one held job
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] submit;
    logic [TIME_W-1:0] start;
  } job_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic             insert;
    logic             pop;
    logic             head_first;
    logic [KEY_W-1:0] new_key;
  } cell_ctl_t;

  // ordering key: submission time plus start offset, never wraps
  function automatic logic [KEY_W-1:0] job_key(input job_t j);
    return KEY_W'(j.submit) + KEY_W'(j.start);
  endfunction

endpackage

@@ src/sjpq_cell.sv @@
// ----------------------------------------------------------------------------
// sjpq_cell
// One slot of the sorted chain: compares its key with the incoming key and
// either keeps its job, takes the new job, or takes a neighbour's job.
// ----------------------------------------------------------------------------
module sjpq_cell (
  input  logic                clk,
  input  sjpq_pkg::cell_ctl_t ctl,
  input  logic                held,
  input  sjpq_pkg::job_t      new_job,
  input  sjpq_pkg::job_t      left_job,
  input  logic                left_after,
  input  sjpq_pkg::job_t      right_job,
  output sjpq_pkg::job_t      job,
  output logic                after
);

  logic [sjpq_pkg::KEY_W-1:0] key;

  // the new job lands at or before this slot
  assign key   = sjpq_pkg::job_key(job);
  assign after = ctl.head_first | ~held | (key > ctl.new_key);

  // slot update: shift right on insert, shift left on pop
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (left_after) begin
        job <= left_job;
      end else if (after) begin
        job <= new_job;
      end
    end else if (ctl.pop) begin
      job <= right_job;
    end
  end

endmodule

@@ src/sorted_job_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_job_priority_queue_top
// Bounded job queue kept in ascending order of submit + start time, built
// as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | opcode job_tag submit_time start_time
//  out     | output    | out_valid/out_stall| status out_tag out_submit out_start
//          |           |                    | occupancy
//
//  One beat per cycle while in_stall is low: every cell compares and shifts in
//  the accepting cycle; the result is in the output register on the next cycle.
//  Reset (rst, synchronous) clears the entry count and the output valid flag;
//  the slot contents and the result fields are left as they are.
//  A held output beat stalls the input only while out_stall is high.
// ----------------------------------------------------------------------------
module sorted_job_priority_queue_top #(
  parameter int unsigned QUEUE_DEPTH = sjpq_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [sjpq_pkg::TAG_W-1:0]    job_tag,
  input  logic [sjpq_pkg::TIME_W-1:0]   submit_time,
  input  logic [sjpq_pkg::TIME_W-1:0]   start_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sjpq_pkg::STATUS_W-1:0] status,
  output logic [sjpq_pkg::TAG_W-1:0]    out_tag,
  output logic [sjpq_pkg::TIME_W-1:0]   out_submit,
  output logic [sjpq_pkg::TIME_W-1:0]   out_start,
  output logic [sjpq_pkg::OCC_W-1:0]    occupancy
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      accept;
  logic                      full;
  logic                      empty;
  sjpq_pkg::job_t            new_job;
  sjpq_pkg::cell_ctl_t       ctl;
  sjpq_pkg::job_t            slot_job [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]    slot_after;
  logic [QUEUE_DEPTH-1:0]    slot_held;
  logic [sjpq_pkg::STATUS_W-1:0] status_next;

  // input handshake
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

  assign new_job.tag    = job_tag;
  assign new_job.submit = submit_time;
  assign new_job.start  = start_time;

  // control broadcast; a tie with the head goes in front of it
  always_comb begin
    ctl.new_key    = sjpq_pkg::job_key(new_job);
    ctl.insert     = accept & (opcode == sjpq_pkg::OP_INSERT) & ~full;
    ctl.pop        = accept & (opcode == sjpq_pkg::OP_POP) & ~empty;
    ctl.head_first = ~empty & (sjpq_pkg::job_key(slot_job[0]) >= ctl.new_key);
  end

  // chain of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sjpq_pkg::job_t left_job;
    sjpq_pkg::job_t right_job;
    logic           left_after;

    assign slot_held[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_job   = new_job;
      assign left_after = 1'b0;
    end else begin : g_inner
      assign left_job   = slot_job[i-1];
      assign left_after = slot_after[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_job = slot_job[i];
    end else begin : g_notlast
      assign right_job = slot_job[i+1];
    end

    sjpq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .held       (slot_held[i]),
      .new_job    (new_job),
      .left_job   (left_job),
      .left_after (left_after),
      .right_job  (right_job),
      .job        (slot_job[i]),
      .after      (slot_after[i])
    );
  end

  // next count and status
  always_comb begin
    count_next = count;
    if (ctl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.pop) begin
      count_next = count - CNT_W'(1);
    end

    if (opcode == sjpq_pkg::OP_INSERT) begin
      status_next = full ? sjpq_pkg::ST_FULL : sjpq_pkg::ST_INSERTED;
    end else begin
      status_next = empty ? sjpq_pkg::ST_EMPTY : sjpq_pkg::ST_POPPED;
    end
  end

  // count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (accept) begin
      status    <= status_next;
      occupancy <= sjpq_pkg::OCC_W'(count_next);
      if (ctl.pop) begin
        out_tag    <= slot_job[0].tag;
        out_submit <= slot_job[0].submit;
        out_start  <= slot_job[0].start;
      end else begin
        out_tag    <= '0;
        out_submit <= '0;
        out_start  <= '0;
      end
    end
  end

endmodule

@@ src/sjpq_check.sv @@
// ----------------------------------------------------------------------------
// sjpq_check
// Port-level checks for the sorted job priority queue, bound to the top.
// ----------------------------------------------------------------------------
module sjpq_check #(
  parameter int unsigned QUEUE_DEPTH = sjpq_pkg::DEFAULT_DEPTH
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sjpq_pkg::STATUS_W-1:0] status,
  input logic [sjpq_pkg::TAG_W-1:0]    out_tag,
  input logic [sjpq_pkg::TIME_W-1:0]   out_submit,
  input logic [sjpq_pkg::TIME_W-1:0]   out_start,
  input logic [sjpq_pkg::OCC_W-1:0]    occupancy
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_tag)
      && $stable(occupancy))
    else $error("result beat changed while stalled");

  // an empty output register never stalls the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  // a pop on empty reports an empty queue
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sjpq_pkg::ST_EMPTY |-> occupancy == '0)
    else $error("empty pop with nonzero occupancy");

  // a dropped insert reports a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == sjpq_pkg::ST_FULL |->
      occupancy == sjpq_pkg::OCC_W'(QUEUE_DEPTH))
    else $error("dropped insert without a full queue");

  // job fields are zero unless a job was popped
  a_zero_job: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != sjpq_pkg::ST_POPPED |->
      out_tag == '0 && out_submit == '0 && out_start == '0)
    else $error("job fields set on a non-pop result");

endmodule

bind sorted_job_priority_queue_top sjpq_check #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_sjpq_check (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .out_tag    (out_tag),
  .out_submit (out_submit),
  .out_start  (out_start),
  .occupancy  (occupancy)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted job priority queue. A driver and a
// monitor run as clocked processes around the block, with random gaps on the
// input and random stalls on the output. A behavioural copy of the sorted
// queue predicts status, popped job and occupancy for every accepted beat.
// Stimulus is a short directed run (empty pop, extreme fields, equal keys,
// full queue) followed by random fill, drain and mixed stretches.
// ----------------------------------------------------------------------------
module tb;

  localparam int QDEPTH      = sjpq_pkg::DEFAULT_DEPTH;
  localparam int CYCLE_LIMIT = 200000;

  // one request for the queue
  typedef struct packed {
    logic           op;
    sjpq_pkg::job_t job;
  } request_t;

  // one predicted result beat
  typedef struct packed {
    logic [sjpq_pkg::STATUS_W-1:0] status;
    logic [sjpq_pkg::TAG_W-1:0]    tag;
    logic [sjpq_pkg::TIME_W-1:0]   submit;
    logic [sjpq_pkg::TIME_W-1:0]   start;
    logic [sjpq_pkg::OCC_W-1:0]    occupancy;
  } outcome_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          opcode = sjpq_pkg::OP_INSERT;
  logic [sjpq_pkg::TAG_W-1:0]    job_tag = '0;
  logic [sjpq_pkg::TIME_W-1:0]   submit_time = '0;
  logic [sjpq_pkg::TIME_W-1:0]   start_time = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [sjpq_pkg::STATUS_W-1:0] status;
  logic [sjpq_pkg::TAG_W-1:0]    out_tag;
  logic [sjpq_pkg::TIME_W-1:0]   out_submit;
  logic [sjpq_pkg::TIME_W-1:0]   out_start;
  logic [sjpq_pkg::OCC_W-1:0]    occupancy;

  request_t job_feed[$];
  outcome_t due_outcomes[$];

  // model of the held jobs, kept sorted by key
  sjpq_pkg::job_t queue_model[QDEPTH];
  int             model_count = 0;

  // handshake bookkeeping shared between the edges
  bit       in_taken = 1'b0;
  bit       out_taken = 1'b0;
  bit       out_held = 1'b0;
  int       tx_gap = 0;
  int       rx_wait = 0;
  bit       tx_calm = 1'b0;
  bit       rx_calm = 1'b0;
  outcome_t head_want;
  int       mismatches = 0;
  int       beats_seen = 0;
  int       status_tally[4] = '{0, 0, 0, 0};
  int       peak_occupancy = 0;
  int       cycle_count = 0;

  sorted_job_priority_queue_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .job_tag    (job_tag),
    .submit_time(submit_time),
    .start_time (start_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_tag    (out_tag),
    .out_submit (out_submit),
    .out_start  (out_start),
    .occupancy  (occupancy)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // ordering key of a job, one bit wider so it never wraps
  function automatic logic [sjpq_pkg::KEY_W-1:0] held_key(input sjpq_pkg::job_t j);
    return {1'b0, j.submit} + {1'b0, j.start};
  endfunction

  // apply one request to the model queue and return the beat it gives
  function automatic outcome_t apply_queue_op(input logic op, input sjpq_pkg::job_t job);
    outcome_t                   res;
    logic [sjpq_pkg::KEY_W-1:0] new_key;
    int                         pos;
    res = '0;
    new_key = held_key(job);
    if (op == sjpq_pkg::OP_INSERT) begin
      if (model_count >= QDEPTH) begin
        res.status = sjpq_pkg::ST_FULL;
      end else begin
        // equal to the head key goes first, otherwise behind all equal keys
        pos = 0;
        if (model_count != 0 && new_key > held_key(queue_model[0])) begin
          while (pos < model_count && held_key(queue_model[pos]) <= new_key)
            pos++;
        end
        for (int i = model_count; i > pos; i--)
          queue_model[i] = queue_model[i-1];
        queue_model[pos] = job;
        model_count++;
        res.status = sjpq_pkg::ST_INSERTED;
      end
    end else begin
      if (model_count == 0) begin
        res.status = sjpq_pkg::ST_EMPTY;
      end else begin
        res.tag    = queue_model[0].tag;
        res.submit = queue_model[0].submit;
        res.start  = queue_model[0].start;
        for (int i = 1; i < model_count; i++)
          queue_model[i-1] = queue_model[i];
        model_count--;
        res.status = sjpq_pkg::ST_POPPED;
      end
    end
    res.occupancy = sjpq_pkg::OCC_W'(model_count);
    return res;
  endfunction

  // wait length for one beat, with occasional stretches of no idling
  function automatic int draw_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  // times mostly from a narrow range so that keys collide often
  function automatic logic [sjpq_pkg::TIME_W-1:0] draw_time();
    if ($urandom_range(0, 3) == 0)
      return sjpq_pkg::TIME_W'($urandom_range(0, 65535));
    return sjpq_pkg::TIME_W'($urandom_range(0, 12));
  endfunction

  task automatic add_job(input logic [sjpq_pkg::TAG_W-1:0] tag,
                         input logic [sjpq_pkg::TIME_W-1:0] sub,
                         input logic [sjpq_pkg::TIME_W-1:0] st);
    request_t r;
    r.op         = sjpq_pkg::OP_INSERT;
    r.job.tag    = tag;
    r.job.submit = sub;
    r.job.start  = st;
    job_feed.push_back(r);
  endtask

  // pop carries random payload, which the block must ignore
  task automatic add_pop();
    request_t r;
    r.op         = sjpq_pkg::OP_POP;
    r.job.tag    = sjpq_pkg::TAG_W'($urandom_range(0, 65535));
    r.job.submit = sjpq_pkg::TIME_W'($urandom_range(0, 65535));
    r.job.start  = sjpq_pkg::TIME_W'($urandom_range(0, 65535));
    job_feed.push_back(r);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // input driver: new beat at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // held beat stays put
    end else if (tx_gap > 0) begin
      in_valid <= 1'b0;
      tx_gap--;
    end else if (job_feed.size() > 0) begin
      opcode      <= job_feed[0].op;
      job_tag     <= job_feed[0].job.tag;
      submit_time <= job_feed[0].job.submit;
      start_time  <= job_feed[0].job.start;
      in_valid    <= 1'b1;
      void'(job_feed.pop_front());
      if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
      tx_gap = draw_gap(tx_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // output stall: each result beat is stalled for its own drawn wait
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      rx_wait = draw_gap(rx_calm);
    end else if (out_held && rx_wait > 0) begin
      rx_wait--;
    end
    out_stall <= !rst && rx_wait != 0;
  end

  // monitor: predict on input beats, check on output beats
  always @(posedge clk) begin
    in_taken  = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
    out_held  = !rst && out_valid && out_stall;
    if (in_taken)
      due_outcomes.push_back(apply_queue_op(opcode, {job_tag, submit_time, start_time}));
    if (out_taken) begin
      beats_seen++;
      if (due_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, status %0d tag %0h occupancy %0d",
                 $time, status, out_tag, occupancy);
      end else begin
        head_want = due_outcomes.pop_front();
        check_field("status", 32'(head_want.status), 32'(status));
        check_field("out_tag", 32'(head_want.tag), 32'(out_tag));
        check_field("out_submit", 32'(head_want.submit), 32'(out_submit));
        check_field("out_start", 32'(head_want.start), 32'(out_start));
        check_field("occupancy", 32'(head_want.occupancy), 32'(occupancy));
      end
      status_tally[status]++;
      if (int'(occupancy) > peak_occupancy) peak_occupancy = int'(occupancy);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int mix;
    int ins_pct;

    // directed: empty pop, extreme fields, equal keys, full queue
    add_pop();
    add_job(16'h0000, 16'h0000, 16'h0000);
    add_job(16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_job(16'h0001, 16'h0000, 16'h0000);
    add_job(16'h0A0A, 16'd5, 16'd5);
    add_job(16'h0B0B, 16'd3, 16'd7);
    add_job(16'h0C0C, 16'd7, 16'd3);
    for (int i = 0; i < 10; i++)
      add_job(sjpq_pkg::TAG_W'(16'h1000 + i), sjpq_pkg::TIME_W'(16'h8000 - i * 3),
              sjpq_pkg::TIME_W'(i * 7));
    add_job(16'h5A5A, 16'h0001, 16'h0001);
    for (int i = 0; i < 3; i++)
      add_pop();

    // random: fill, drain and balanced stretches
    mix = 0;
    for (int n = 0; n < 500; n++) begin
      if (n % 40 == 0) mix = int'($urandom_range(0, 2));
      ins_pct = (mix == 0) ? 85 : (mix == 1) ? 15 : 50;
      if ($urandom_range(0, 99) < ins_pct)
        add_job(sjpq_pkg::TAG_W'($urandom_range(0, 65535)), draw_time(), draw_time());
      else
        add_pop();
    end

    // reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain everything, then leave room for stray beats
    while (job_feed.size() != 0 || in_valid) @(posedge clk);
    while (due_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d result beats: %0d inserted, %0d popped, %0d empty pops, %0d full drops",
             beats_seen, status_tally[sjpq_pkg::ST_INSERTED],
             status_tally[sjpq_pkg::ST_POPPED], status_tally[sjpq_pkg::ST_EMPTY],
             status_tally[sjpq_pkg::ST_FULL]);
    $display("Peak occupancy %0d of %0d, %0d mismatches", peak_occupancy, QDEPTH, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
